### src/srrp_pkg.sv
// shared types, constants and register indexes for the socks5 request/reply parser
package srrp_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_VERSION = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IPV4_TYPE_CODE   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_DOMAIN_TYPE_CODE = 2'd2;

  localparam logic [7:0] RST_EXPECTED_VERSION = 8'd5;
  localparam logic [7:0] RST_IPV4_TYPE_CODE   = 8'd1;
  localparam logic [7:0] RST_DOMAIN_TYPE_CODE = 8'd3;

  // header bytes plus port bytes; a message this long or shorter is too short
  localparam logic [3:0] MIN_LEN_EXCL = 4'(1 + 1 + 1 + 2 + 2);
  localparam logic [3:0] LEN_SAT      = 4'd8;
  localparam logic [7:0] IPV4_LEN     = 8'd4;

  typedef enum logic [3:0] {
    PH_VER, PH_CODE, PH_RSV, PH_TYPE, PH_IPV4, PH_DLEN, PH_DOM,
    PH_PHI, PH_PLO, PH_TRAIL, PH_BADTYPE
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK, ST_TOO_SHORT, ST_BAD_VERSION, ST_BAD_TYPE, ST_SHORT_ADDR, ST_SHORT_PORT
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_beat_t;

  typedef struct packed {
    logic       addr_valid;
    logic [7:0] addr_byte;
    logic       done_res;
    logic [2:0] status;
    logic [7:0] code;
    logic [7:0] addr_type;
    logic [15:0] port;
  } out_beat_t;

  // classified byte handed from front to back
  typedef struct packed {
    logic        addr_valid;
    logic [7:0]  addr_byte;
    logic        last;
    logic        too_short;
    logic        version_bad;
    phase_t      phase;
    logic [7:0]  code;
    logic [7:0]  addr_type;
    logic [15:0] port;
  } work_t;

endpackage

### src/srrp_chan_if.sv
// valid/ready channel carrying one beat of a given payload type
interface srrp_chan_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

### src/srrp_front.sv
// front end: configuration registers, byte parser and classification of each beat
module srrp_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [srrp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [srrp_pkg::CFG_DATA_W-1:0]     cfg_data,
  srrp_chan_if.sink                           in_chan,
  input  logic                                queue_full,
  output logic                                push,
  output srrp_pkg::work_t                     push_data
);

  logic [7:0] expected_version;
  logic [7:0] ipv4_type_code;
  logic [7:0] domain_type_code;

  srrp_pkg::phase_t phase, phase_next;
  logic [3:0]  length_seen, length_seen_next;
  logic [7:0]  address_remaining, address_remaining_next;
  logic [7:0]  code_held, code_held_next;
  logic [7:0]  type_held, type_held_next;
  logic        version_bad, version_bad_next;
  logic [15:0] port_held, port_held_next;

  logic [7:0]  b;
  logic        addr_valid;
  logic [7:0]  rem_dec;

  assign in_chan.ready = !queue_full;
  assign push          = in_chan.valid && in_chan.ready;
  assign b             = in_chan.payload.data_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version <= srrp_pkg::RST_EXPECTED_VERSION;
      ipv4_type_code   <= srrp_pkg::RST_IPV4_TYPE_CODE;
      domain_type_code <= srrp_pkg::RST_DOMAIN_TYPE_CODE;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        srrp_pkg::CFG_EXPECTED_VERSION: expected_version <= cfg_data;
        srrp_pkg::CFG_IPV4_TYPE_CODE:   ipv4_type_code   <= cfg_data;
        srrp_pkg::CFG_DOMAIN_TYPE_CODE: domain_type_code <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next             = phase;
    length_seen_next       = (length_seen < srrp_pkg::LEN_SAT) ? length_seen + 4'd1
                                                               : length_seen;
    address_remaining_next = address_remaining;
    code_held_next         = code_held;
    type_held_next         = type_held;
    version_bad_next       = version_bad;
    port_held_next         = port_held;
    addr_valid             = 1'b0;
    rem_dec                = (address_remaining != 8'd0) ? address_remaining - 8'd1
                                                         : address_remaining;

    case (phase)
      srrp_pkg::PH_VER: begin
        version_bad_next = (b != expected_version);
        phase_next       = srrp_pkg::PH_CODE;
      end
      srrp_pkg::PH_CODE: begin
        code_held_next = b;
        phase_next     = srrp_pkg::PH_RSV;
      end
      srrp_pkg::PH_RSV: begin
        phase_next = srrp_pkg::PH_TYPE;
      end
      srrp_pkg::PH_TYPE: begin
        type_held_next = b;
        if (b == ipv4_type_code) begin
          address_remaining_next = srrp_pkg::IPV4_LEN;
          phase_next             = srrp_pkg::PH_IPV4;
        end else if (b == domain_type_code) begin
          phase_next = srrp_pkg::PH_DLEN;
        end else begin
          phase_next = srrp_pkg::PH_BADTYPE;
        end
      end
      srrp_pkg::PH_IPV4, srrp_pkg::PH_DOM: begin
        addr_valid             = 1'b1;
        address_remaining_next = rem_dec;
        if (rem_dec == 8'd0) phase_next = srrp_pkg::PH_PHI;
      end
      srrp_pkg::PH_DLEN: begin
        address_remaining_next = b;
        phase_next = (b == 8'd0) ? srrp_pkg::PH_PHI : srrp_pkg::PH_DOM;
      end
      srrp_pkg::PH_PHI: begin
        port_held_next = {b, 8'd0};
        phase_next     = srrp_pkg::PH_PLO;
      end
      srrp_pkg::PH_PLO: begin
        port_held_next = {port_held[15:8], b};
        phase_next     = srrp_pkg::PH_TRAIL;
      end
      default: ;
    endcase

    push_data.addr_valid  = addr_valid;
    push_data.addr_byte   = addr_valid ? b : 8'd0;
    push_data.last        = in_chan.payload.last;
    push_data.too_short   = (length_seen_next <= srrp_pkg::MIN_LEN_EXCL);
    push_data.version_bad = version_bad_next;
    push_data.phase       = phase_next;
    push_data.code        = code_held_next;
    push_data.addr_type   = type_held_next;
    push_data.port        = port_held_next;

    // closing byte starts a fresh message
    if (in_chan.payload.last) begin
      phase_next             = srrp_pkg::PH_VER;
      length_seen_next       = 4'd0;
      address_remaining_next = 8'd0;
      code_held_next         = 8'd0;
      type_held_next         = 8'd0;
      version_bad_next       = 1'b0;
      port_held_next         = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= srrp_pkg::PH_VER;
      length_seen       <= 4'd0;
      address_remaining <= 8'd0;
      code_held         <= 8'd0;
      type_held         <= 8'd0;
      version_bad       <= 1'b0;
      port_held         <= 16'd0;
    end else if (push) begin
      phase             <= phase_next;
      length_seen       <= length_seen_next;
      address_remaining <= address_remaining_next;
      code_held         <= code_held_next;
      type_held         <= type_held_next;
      version_bad       <= version_bad_next;
      port_held         <= port_held_next;
    end
  end

endmodule

### src/srrp_queue.sv
// short fifo of classified beats between front and back
module srrp_queue #(
  parameter int unsigned DEPTH = srrp_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  srrp_pkg::work_t push_data,
  output logic            full,
  input  logic            pop_ready,
  output logic            pop_valid,
  output srrp_pkg::work_t pop_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  srrp_pkg::work_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = entries[rd_ptr];
  assign pop       = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### src/srrp_back.sv
// back end: status resolution and registered result output
module srrp_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            pop_valid,
  input  srrp_pkg::work_t pop_data,
  output logic            pop_ready,
  srrp_chan_if.source     out_chan
);

  srrp_pkg::out_beat_t result;
  srrp_pkg::status_t   status;
  logic                load;

  assign load      = !out_chan.valid || out_chan.ready;
  assign pop_ready = load;

  always_comb begin
    if (pop_data.too_short)
      status = srrp_pkg::ST_TOO_SHORT;
    else if (pop_data.version_bad)
      status = srrp_pkg::ST_BAD_VERSION;
    else if (pop_data.phase == srrp_pkg::PH_BADTYPE)
      status = srrp_pkg::ST_BAD_TYPE;
    else if (pop_data.phase == srrp_pkg::PH_IPV4 || pop_data.phase == srrp_pkg::PH_DLEN ||
             pop_data.phase == srrp_pkg::PH_DOM)
      status = srrp_pkg::ST_SHORT_ADDR;
    else if (pop_data.phase == srrp_pkg::PH_PHI || pop_data.phase == srrp_pkg::PH_PLO)
      status = srrp_pkg::ST_SHORT_PORT;
    else
      status = srrp_pkg::ST_OK;

    result.addr_valid = pop_data.addr_valid;
    result.addr_byte  = pop_data.addr_byte;
    result.done_res   = pop_data.last;
    result.status     = pop_data.last ? status : srrp_pkg::ST_OK;
    result.code       = pop_data.last ? pop_data.code : 8'd0;
    result.addr_type  = pop_data.last ? pop_data.addr_type : 8'd0;
    result.port       = (pop_data.last && status == srrp_pkg::ST_OK) ? pop_data.port
                                                                     : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_chan.valid <= 1'b0;
    end else if (load) begin
      out_chan.valid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && pop_valid) out_chan.payload <= result;
  end

endmodule

### src/socks5_request_reply_parser_core.sv
// top level of the socks5 request/reply byte parser
// Takes one message byte per beat and returns one result beat per byte, one
// byte per clock sustained while the output is not stalled: the parser state
// is updated for each accepted byte in the front end, and a short fifo plus
// an output register decouple it from the consumer. Each accepted byte is
// classified into the fifo, then its result goes to the output register and
// is held there until taken. Address octets and domain characters come out
// flagged with addr_valid as they arrive; the byte marked last carries
// done_res with the status, code, address type and port, and the parser
// then starts over. Configuration writes are taken at any time but should
// be made while no message is in flight.
module socks5_request_reply_parser_core #(
  parameter int unsigned QUEUE_DEPTH = srrp_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [srrp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [srrp_pkg::CFG_DATA_W-1:0]  cfg_data,
  srrp_chan_if.sink                        in_chan,
  srrp_chan_if.source                      out_chan
);

  logic            push;
  srrp_pkg::work_t push_data;
  logic            queue_full;
  logic            pop_ready;
  logic            pop_valid;
  srrp_pkg::work_t pop_data;

  srrp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_chan    (in_chan),
    .queue_full (queue_full),
    .push       (push),
    .push_data  (push_data)
  );

  srrp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop_ready (pop_ready),
    .pop_valid (pop_valid),
    .pop_data  (pop_data)
  );

  srrp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop_ready (pop_ready),
    .out_chan  (out_chan)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    queue_full |-> !push)
    else $error("push into full queue");

  a_idle_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_chan.valid)
    else $error("result valid right after reset");

  a_fields_only_on_done: assert property (@(posedge clk) disable iff (rst)
    (out_chan.valid && !out_chan.payload.done_res) |->
      (out_chan.payload.status == srrp_pkg::ST_OK && out_chan.payload.code == 8'd0 &&
       out_chan.payload.addr_type == 8'd0 && out_chan.payload.port == 16'd0))
    else $error("message fields set on a beat that is not last");

  a_port_only_when_ok: assert property (@(posedge clk) disable iff (rst)
    (out_chan.valid && out_chan.payload.status != srrp_pkg::ST_OK) |->
      out_chan.payload.port == 16'd0)
    else $error("port reported with a failing status");

endmodule

### verif/tb_top.sv
// self-checking testbench for the socks5 request/reply parser core
`timescale 1ns / 1ps

module tb_top;
  import srrp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_BEATS = 215;
  localparam int unsigned CALM_AFTER  = 1150;

  typedef struct {
    in_beat_t  beat;
    bit        known;
    out_beat_t res;
  } stim_row_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  srrp_chan_if #(.payload_t(in_beat_t))  in_if ();
  srrp_chan_if #(.payload_t(out_beat_t)) out_if ();

  socks5_request_reply_parser_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_chan   (in_if),
    .out_chan  (out_if)
  );

  // parser shadow: configuration and per-message state
  logic [7:0]  want_version;
  logic [7:0]  ipv4_code;
  logic [7:0]  domain_code;
  phase_t      msg_phase;
  logic [3:0]  byte_count;
  logic [7:0]  addr_left;
  logic [7:0]  code_seen;
  logic [7:0]  atype_seen;
  logic        version_mismatch;
  logic [15:0] port_seen;

  out_beat_t   parsed_beats[$];
  stim_row_t   stim_rows[$];
  int unsigned mismatches;
  int unsigned beats_sent;
  int unsigned cycle_count;
  bit          idle_on;
  int unsigned gap_odds;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  function automatic void restart_message();
    msg_phase        = PH_VER;
    byte_count       = '0;
    addr_left        = '0;
    code_seen        = '0;
    atype_seen       = '0;
    version_mismatch = 1'b0;
    port_seen        = '0;
  endfunction

  function automatic out_beat_t parse_byte(in_beat_t beat);
    out_beat_t r;
    logic [7:0] d;
    r = '0;
    d = beat.data_byte;
    if (byte_count < LEN_SAT) byte_count++;
    case (msg_phase)
      PH_VER: begin
        version_mismatch = (d != want_version);
        msg_phase = PH_CODE;
      end
      PH_CODE: begin
        code_seen = d;
        msg_phase = PH_RSV;
      end
      PH_RSV: msg_phase = PH_TYPE;
      PH_TYPE: begin
        atype_seen = d;
        if (d == ipv4_code) begin
          addr_left = IPV4_LEN;
          msg_phase = PH_IPV4;
        end else if (d == domain_code) begin
          msg_phase = PH_DLEN;
        end else begin
          msg_phase = PH_BADTYPE;
        end
      end
      PH_IPV4, PH_DOM: begin
        r.addr_valid = 1'b1;
        r.addr_byte  = d;
        if (addr_left != 0) addr_left--;
        if (addr_left == 0) msg_phase = PH_PHI;
      end
      PH_DLEN: begin
        addr_left = d;
        msg_phase = (d == 8'd0) ? PH_PHI : PH_DOM;
      end
      PH_PHI: begin
        port_seen = {d, 8'h00};
        msg_phase = PH_PLO;
      end
      PH_PLO: begin
        port_seen = port_seen | {8'h00, d};
        msg_phase = PH_TRAIL;
      end
      default: ;
    endcase
    if (beat.last) begin
      r.done_res  = 1'b1;
      r.code      = code_seen;
      r.addr_type = atype_seen;
      if (byte_count <= MIN_LEN_EXCL) r.status = ST_TOO_SHORT;
      else if (version_mismatch) r.status = ST_BAD_VERSION;
      else if (msg_phase == PH_BADTYPE) r.status = ST_BAD_TYPE;
      else if (msg_phase inside {PH_IPV4, PH_DLEN, PH_DOM}) r.status = ST_SHORT_ADDR;
      else if (msg_phase inside {PH_PHI, PH_PLO}) r.status = ST_SHORT_PORT;
      else r.status = ST_OK;
      if (r.status == ST_OK) r.port = port_seen;
      restart_message();
    end
    return r;
  endfunction

  function automatic void add_plain(logic [7:0] d);
    stim_row_t row;
    row.beat.data_byte = d;
    row.beat.last      = 1'b0;
    row.known          = 1'b0;
    row.res            = '0;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_closing(logic [7:0] d, logic av, status_t st, logic [7:0] cd,
                                      logic [7:0] ty, logic [15:0] pt);
    stim_row_t row;
    row.beat.data_byte = d;
    row.beat.last      = 1'b1;
    row.known          = 1'b1;
    row.res            = '0;
    row.res.addr_valid = av;
    row.res.addr_byte  = av ? d : 8'h00;
    row.res.done_res   = 1'b1;
    row.res.status     = st;
    row.res.code       = cd;
    row.res.addr_type  = ty;
    row.res.port       = pt;
    stim_rows.push_back(row);
  endfunction

  task automatic send_beat(in_beat_t beat, bit known, out_beat_t known_res);
    out_beat_t predicted;
    if (idle_on && gap_odds != 0 && $urandom_range(1, 100) <= gap_odds) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= beat;
    do @(posedge clk); while (!in_if.ready);
    predicted = parse_byte(beat);
    parsed_beats.push_back(known ? known_res : predicted);
    beats_sent++;
  endtask

  task automatic send_message();
    logic [7:0] msg[$];
    logic [7:0] b;
    in_beat_t   beat;
    int         kind;
    int         dlen;
    int         cut;
    kind = $urandom_range(0, 99);
    case ($urandom_range(0, 2))
      0: gap_odds = 0;
      1: gap_odds = 15;
      default: gap_odds = 40;
    endcase
    msg.push_back(want_version);
    msg.push_back(8'($urandom_range(0, 255)));
    msg.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 1)) begin
      msg.push_back(ipv4_code);
      repeat (4) msg.push_back(8'($urandom_range(0, 255)));
    end else begin
      msg.push_back(domain_code);
      dlen = ($urandom_range(0, 39) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 10);
      msg.push_back(8'(dlen));
      repeat (dlen) msg.push_back(8'($urandom_range(0, 255)));
    end
    repeat (2) msg.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) msg.push_back(8'($urandom_range(0, 255)));
    end
    if (kind >= 70 && kind < 80) begin
      cut = $urandom_range(1, msg.size() - 1);
      while (msg.size() > cut) void'(msg.pop_back());
    end else if (kind >= 80 && kind < 88) begin
      msg[0] = want_version ^ 8'($urandom_range(1, 255));
    end else if (kind >= 88 && kind < 94) begin
      do b = 8'($urandom_range(0, 255)); while (b == ipv4_code || b == domain_code);
      msg[3] = b;
    end else if (kind >= 94) begin
      msg.delete();
      repeat ($urandom_range(1, 12)) msg.push_back(8'($urandom_range(0, 255)));
    end
    foreach (msg[i]) begin
      beat.data_byte = msg[i];
      beat.last      = (i == msg.size() - 1);
      send_beat(beat, 1'b0, '0);
    end
  endtask

  task automatic quiesce();
    in_if.valid <= 1'b0;
    while (parsed_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(logic [7:0] ver, logic [7:0] v4, logic [7:0] dom);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_EXPECTED_VERSION;
    cfg_data  <= ver;
    @(posedge clk);
    cfg_index <= CFG_IPV4_TYPE_CODE;
    cfg_data  <= v4;
    @(posedge clk);
    cfg_index <= CFG_DOMAIN_TYPE_CODE;
    cfg_data  <= dom;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    want_version = ver;
    ipv4_code    = v4;
    domain_code  = dom;
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    out_beat_t want;
    out_beat_t got;
    if (!rst && out_if.valid && out_if.ready) begin
      got = out_if.payload;
      if (parsed_beats.size() == 0) begin
        $error("result beat with nothing outstanding");
        mismatches++;
      end else begin
        want = parsed_beats.pop_front();
        check_field("addr_valid", 16'(want.addr_valid), 16'(got.addr_valid));
        check_field("addr_byte", 16'(want.addr_byte), 16'(got.addr_byte));
        check_field("done_res", 16'(want.done_res), 16'(got.done_res));
        check_field("status", 16'(want.status), 16'(got.status));
        check_field("code", 16'(want.code), 16'(got.code));
        check_field("addr_type", 16'(want.addr_type), 16'(got.addr_type));
        check_field("port", want.port, got.port);
      end
    end
  end

  initial begin
    out_if.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(20, 60)) @(posedge clk);
      else repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  initial begin : stimulus
    int unsigned phase_start;
    logic [7:0]  v;
    logic [7:0]  t;
    rst           <= 1'b1;
    cfg_wr_en     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    in_if.valid   <= 1'b0;
    in_if.payload <= '0;
    mismatches    = 0;
    beats_sent    = 0;
    cycle_count   = 0;
    idle_on       = 1'b1;
    gap_odds      = 25;
    want_version  = RST_EXPECTED_VERSION;
    ipv4_code     = RST_IPV4_TYPE_CODE;
    domain_code   = RST_DOMAIN_TYPE_CODE;
    restart_message();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // lone byte
    add_closing(8'h05, 1'b0, ST_TOO_SHORT, 8'h00, 8'h00, 16'h0000);
    // wrong version, ipv4 octets still forwarded
    add_plain(8'h00); add_plain(8'h00); add_plain(8'hFF); add_plain(8'h01);
    add_plain(8'h00); add_plain(8'hFF); add_plain(8'h00); add_plain(8'hFF);
    add_plain(8'hFF);
    add_closing(8'hFF, 1'b0, ST_BAD_VERSION, 8'h00, 8'h01, 16'h0000);
    // empty domain, port, then a trailing byte
    add_plain(8'h05); add_plain(8'h7E); add_plain(8'h00); add_plain(8'h03);
    add_plain(8'h00); add_plain(8'h12); add_plain(8'h34);
    add_closing(8'hA5, 1'b0, ST_OK, 8'h7E, 8'h03, 16'h1234);
    // domain length runs past the end
    add_plain(8'h05); add_plain(8'h02); add_plain(8'h00); add_plain(8'h03);
    add_plain(8'h05); add_plain(8'h61); add_plain(8'h62);
    add_closing(8'h63, 1'b1, ST_SHORT_ADDR, 8'h02, 8'h03, 16'h0000);
    // unknown address type
    add_plain(8'h05); add_plain(8'hFF); add_plain(8'h00); add_plain(8'h00);
    add_plain(8'h80); add_plain(8'h80); add_plain(8'h80);
    add_closing(8'h80, 1'b0, ST_BAD_TYPE, 8'hFF, 8'h00, 16'h0000);

    foreach (stim_rows[i]) send_beat(stim_rows[i].beat, stim_rows[i].known, stim_rows[i].res);

    for (int p = 0; p < 6; p++) begin
      if (p != 0) begin
        quiesce();
        case (p)
          1: program_regs(8'h00, 8'hFF, 8'h00);
          2: program_regs(8'hFF, 8'h00, 8'hFF);
          3: program_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)));
          4: begin
            v = 8'($urandom_range(0, 255));
            t = 8'($urandom_range(0, 255));
            program_regs(v, t, t);
          end
          default: program_regs(RST_EXPECTED_VERSION, RST_IPV4_TYPE_CODE,
                                RST_DOMAIN_TYPE_CODE);
        endcase
      end
      phase_start = beats_sent;
      while (beats_sent - phase_start < PHASE_BEATS) begin
        if (beats_sent >= CALM_AFTER) idle_on = 1'b0;
        send_message();
      end
    end

    quiesce();
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
